// ===== rtl/slrq_pkg.sv =====
// Shared types, codes and parse tables of the SLR expression-to-quadruple block.
// Used by slrq_seq, slrq_dp and the top level under rtl/. Depends on nothing.
package slrq_pkg;

	// Request and result payloads.
	typedef struct packed {
		logic [2:0]  token_kind;
		logic [15:0] token_value;
	} token_t;

	typedef struct packed {
		logic        item_type;
		logic        quad_op;
		logic [1:0]  left_kind;
		logic [15:0] left_value;
		logic [1:0]  right_kind;
		logic [15:0] right_value;
		logic [7:0]  result_temp;
		logic [9:0]  quad_number;
		logic [1:0]  status;
		logic        last;
	} result_t;

	// Token kinds.
	localparam logic [2:0] TK_ID    = 3'd0;
	localparam logic [2:0] TK_INT   = 3'd1;
	localparam logic [2:0] TK_PLUS  = 3'd2;
	localparam logic [2:0] TK_TIMES = 3'd3;
	localparam logic [2:0] TK_LPAR  = 3'd4;
	localparam logic [2:0] TK_RPAR  = 3'd5;
	localparam logic [2:0] TK_END   = 3'd6;
	localparam logic [2:0] TK_OTHER = 3'd7;

	// Action table columns.
	localparam logic [2:0] COL_ID   = 3'd0;
	localparam logic [2:0] COL_PLUS = 3'd1;
	localparam logic [2:0] COL_MUL  = 3'd2;
	localparam logic [2:0] COL_LPAR = 3'd3;
	localparam logic [2:0] COL_RPAR = 3'd4;
	localparam logic [2:0] COL_END  = 3'd5;
	localparam logic [2:0] COL_NONE = 3'd7;

	// Status codes.
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_ACC = 2'd1;
	localparam logic [1:0] ST_SYN = 2'd2;
	localparam logic [1:0] ST_OVF = 2'd3;

	// Operand kinds; the mark kind tags stack slots of non-operand tokens.
	localparam logic [1:0] OPK_ID    = 2'd0;
	localparam logic [1:0] OPK_CONST = 2'd1;
	localparam logic [1:0] OPK_TEMP  = 2'd2;
	localparam logic [1:0] OPK_MARK  = 2'd3;

	localparam logic ITEM_QUAD   = 1'b0;
	localparam logic ITEM_STATUS = 1'b1;
	localparam logic QOP_ADD     = 1'b0;
	localparam logic QOP_MUL     = 1'b1;

	localparam logic [9:0] QUAD_BASE  = 10'd100;
	localparam logic [3:0] ITER_LIMIT = 4'd8;
	localparam logic [1:0] MAX_QUADS  = 2'd2;
	localparam logic [3:0] LAST_STATE = 4'd9;

	// Action codes. Bit 4 set means shift to the state in the low bits.
	localparam logic [4:0] A_ERR  = 5'h00;
	localparam logic [4:0] A_ACC  = 5'h01;
	localparam logic [4:0] A_RADD = 5'h02;
	localparam logic [4:0] A_RMUL = 5'h03;
	localparam logic [4:0] A_RPAR = 5'h04;
	localparam logic [4:0] A_RID  = 5'h05;
	localparam logic [4:0] SH2    = 5'h12;
	localparam logic [4:0] SH3    = 5'h13;
	localparam logic [4:0] SH4    = 5'h14;
	localparam logic [4:0] SH5    = 5'h15;
	localparam logic [4:0] SH9    = 5'h19;

	localparam logic [4:0] ACTION_TABLE [0:9][0:5] = '{
		'{SH3,   A_ERR,  A_ERR,  SH2,   A_ERR,  A_ERR },
		'{A_ERR, SH4,    SH5,    A_ERR, A_ERR,  A_ACC },
		'{SH3,   A_ERR,  A_ERR,  SH2,   A_ERR,  A_ERR },
		'{A_ERR, A_RID,  A_RID,  A_ERR, A_RID,  A_RID },
		'{SH3,   A_ERR,  A_ERR,  SH2,   A_ERR,  A_ERR },
		'{SH3,   A_ERR,  A_ERR,  SH2,   A_ERR,  A_ERR },
		'{A_ERR, SH4,    SH5,    A_ERR, SH9,    A_ERR },
		'{A_ERR, A_RADD, SH5,    A_ERR, A_RADD, A_RADD},
		'{A_ERR, A_RMUL, A_RMUL, A_ERR, A_RMUL, A_RMUL},
		'{A_ERR, A_RPAR, A_RPAR, A_ERR, A_RPAR, A_RPAR}
	};

	// Goto on E. Bit 4 set marks a filled cell.
	localparam logic [4:0] G_NONE = 5'h00;
	localparam logic [4:0] GOTO_TABLE [0:9] = '{
		5'h11, G_NONE, 5'h16, G_NONE, 5'h17, 5'h18, G_NONE, G_NONE, G_NONE, G_NONE
	};

	function automatic logic [2:0] token_column(input logic [2:0] kind);
		logic [2:0] col;
		case (kind)
			TK_ID, TK_INT: col = COL_ID;
			TK_PLUS:  col = COL_PLUS;
			TK_TIMES: col = COL_MUL;
			TK_LPAR:  col = COL_LPAR;
			TK_RPAR:  col = COL_RPAR;
			TK_END:   col = COL_END;
			default:  col = COL_NONE;
		endcase
		return col;
	endfunction

	function automatic logic [4:0] slr_action(input logic [3:0] s, input logic [2:0] col);
		logic [4:0] act;
		if (s > LAST_STATE || col > COL_END) begin
			act = A_ERR;
		end else begin
			act = ACTION_TABLE[s][col];
		end
		return act;
	endfunction

	function automatic logic [4:0] slr_goto(input logic [3:0] s);
		logic [4:0] g;
		if (s > LAST_STATE) begin
			g = G_NONE;
		end else begin
			g = GOTO_TABLE[s];
		end
		return g;
	endfunction

	// Microcode: step addresses, datapath operations, sequencing modes.
	localparam logic [3:0] U_IDLE  = 4'd0;
	localparam logic [3:0] U_DEC   = 4'd1;
	localparam logic [3:0] U_SHIFT = 4'd2;
	localparam logic [3:0] U_RID   = 4'd3;
	localparam logic [3:0] U_RB0   = 4'd4;
	localparam logic [3:0] U_RB1   = 4'd5;
	localparam logic [3:0] U_RB2   = 4'd6;
	localparam logic [3:0] U_RP0   = 4'd7;
	localparam logic [3:0] U_RP1   = 4'd8;
	localparam logic [3:0] U_GOTO  = 4'd9;
	localparam logic [3:0] U_STAT  = 4'd10;

	typedef enum logic [3:0] {
		DP_NONE, DP_LATCH, DP_DECODE, DP_SHIFT, DP_RID, DP_RB0, DP_RB1, DP_RB2,
		DP_RP0, DP_RP1, DP_GOTO, DP_STAT
	} dp_op_t;

	typedef enum logic [2:0] {
		SQ_NEXT, SQ_JUMP, SQ_WAIT_IN, SQ_DISPATCH, SQ_WAIT_OUT, SQ_GOTO
	} seq_mode_t;

	typedef enum logic [2:0] {
		DSP_STAT, DSP_SHIFT, DSP_RID, DSP_RBIN, DSP_RPAR
	} dsp_t;

	typedef struct packed {
		dp_op_t     op;
		seq_mode_t  seq;
		logic [3:0] target;
		logic       take_token;
	} ucode_t;

	// Sequencer to datapath.
	typedef struct packed {
		dp_op_t op;
		logic   take_token;
	} ctrl_t;

	// Datapath to sequencer.
	typedef struct packed {
		dsp_t dispatch;
		logic goto_ok;
		logic out_free;
	} cond_t;

endpackage

// ===== rtl/slrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the parser stacks. Depends on nothing.
module slrq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/slrq_seq.sv =====
// Microcode sequencer: step counter, control store and dispatch table.
// Depends on slrq_pkg.
module slrq_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            token_valid,
	input  slrq_pkg::cond_t cond,
	output slrq_pkg::ctrl_t ctrl
);
	import slrq_pkg::*;

	function automatic ucode_t ucode_rom(input logic [3:0] addr);
		ucode_t w;
		case (addr)
			U_IDLE:  w = '{op: DP_LATCH,  seq: SQ_WAIT_IN,  target: U_DEC,  take_token: 1'b1};
			U_DEC:   w = '{op: DP_DECODE, seq: SQ_DISPATCH, target: U_STAT, take_token: 1'b0};
			U_SHIFT: w = '{op: DP_SHIFT,  seq: SQ_JUMP,     target: U_STAT, take_token: 1'b0};
			U_RID:   w = '{op: DP_RID,    seq: SQ_JUMP,     target: U_GOTO, take_token: 1'b0};
			U_RB0:   w = '{op: DP_RB0,    seq: SQ_NEXT,     target: U_RB1,  take_token: 1'b0};
			U_RB1:   w = '{op: DP_RB1,    seq: SQ_NEXT,     target: U_RB2,  take_token: 1'b0};
			U_RB2:   w = '{op: DP_RB2,    seq: SQ_WAIT_OUT, target: U_GOTO, take_token: 1'b0};
			U_RP0:   w = '{op: DP_RP0,    seq: SQ_NEXT,     target: U_RP1,  take_token: 1'b0};
			U_RP1:   w = '{op: DP_RP1,    seq: SQ_JUMP,     target: U_GOTO, take_token: 1'b0};
			U_GOTO:  w = '{op: DP_GOTO,   seq: SQ_GOTO,     target: U_DEC,  take_token: 1'b0};
			U_STAT:  w = '{op: DP_STAT,   seq: SQ_WAIT_OUT, target: U_IDLE, take_token: 1'b0};
			default: w = '{op: DP_NONE,   seq: SQ_JUMP,     target: U_IDLE, take_token: 1'b0};
		endcase
		return w;
	endfunction

	function automatic logic [3:0] dispatch_rom(input dsp_t d);
		logic [3:0] t;
		case (d)
			DSP_SHIFT: t = U_SHIFT;
			DSP_RID:   t = U_RID;
			DSP_RBIN:  t = U_RB0;
			DSP_RPAR:  t = U_RP0;
			default:   t = U_STAT;
		endcase
		return t;
	endfunction

	logic [3:0] upc_q;
	logic [3:0] upc_d;
	ucode_t     uw;

	assign uw = ucode_rom(upc_q);
	assign ctrl = '{op: uw.op, take_token: uw.take_token};

	always_comb begin
		case (uw.seq)
			SQ_NEXT:     upc_d = upc_q + 4'd1;
			SQ_JUMP:     upc_d = uw.target;
			SQ_WAIT_IN:  upc_d = token_valid ? uw.target : upc_q;
			SQ_DISPATCH: upc_d = dispatch_rom(cond.dispatch);
			SQ_WAIT_OUT: upc_d = cond.out_free ? uw.target : upc_q;
			SQ_GOTO:     upc_d = cond.goto_ok ? uw.target : U_STAT;
			default:     upc_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// ===== rtl/slrq_dp.sv =====
// Parser datapath: state and operand stacks, counters, table lookup, output register.
// Depends on slrq_pkg and slrq_ram.
module slrq_dp #(
	parameter int STACK_DEPTH = 32,
	parameter int VALUE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slrq_pkg::ctrl_t   ctrl,
	input  logic              token_valid,
	input  slrq_pkg::token_t  token,
	input  logic              result_ready,
	output logic              result_valid,
	output slrq_pkg::result_t result,
	output slrq_pkg::cond_t   cond
);
	import slrq_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int OW = VALUE_BITS + 2;

	logic [2:0]            tok_kind_q;
	logic [VALUE_BITS-1:0] tok_val_q;
	logic [1:0]            status_q;
	logic [3:0]            iter_q;
	logic [1:0]            nres_q;
	logic [AW-1:0]         top_q;
	logic [3:0]            cur_state_q;
	logic [7:0]            temp_q;
	logic [9:0]            quad_q;
	logic [OW-1:0]         right_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic          ps_we, ps_re;
	logic [AW-1:0] ps_waddr, ps_raddr;
	logic [3:0]    ps_wdata, ps_rdata;
	logic          op_we, op_re;
	logic [AW-1:0] op_waddr, op_raddr;
	logic [OW-1:0] op_wdata, op_rdata;

	logic [2:0]    col;
	logic [4:0]    act;
	logic          full;
	logic          top_ge3;
	logic [AW-1:0] top_inc, top_dec1, top_dec2, top_dec3;
	logic [3:0]    gsrc;
	logic [4:0]    gnext;
	logic          goto_ok;
	logic          out_free;
	logic [7:0]    temp_next;
	logic [OW-1:0] tok_opnd;
	logic [1:0]    dec_status;
	dsp_t          dec_dsp;
	logic          load_quad, load_status;
	result_t       out_d;

	assign col      = token_column(tok_kind_q);
	assign act      = slr_action(cur_state_q, col);
	assign full     = ({1'b0, top_q} + (AW+1)'(1)) >= (AW+1)'(STACK_DEPTH);
	assign top_ge3  = top_q >= AW'(3);
	assign top_inc  = top_q + AW'(1);
	assign top_dec1 = top_q - AW'(1);
	assign top_dec2 = top_q - AW'(2);
	assign top_dec3 = top_q - AW'(3);

	// Entry zero of the state stack is never written; state 0 is used when the pointer is zero.
	assign gsrc      = (top_q == '0) ? 4'd0 : ps_rdata;
	assign gnext     = slr_goto(gsrc);
	assign goto_ok   = gnext[4] && !full;
	assign out_free  = !out_valid_q || result_ready;
	assign temp_next = temp_q + 8'd1;
	assign tok_opnd  = (tok_kind_q <= TK_INT) ? {tok_kind_q[1:0], tok_val_q}
	                                          : {OPK_MARK, VALUE_BITS'(0)};

	always_comb begin
		dec_dsp    = DSP_STAT;
		dec_status = ST_SYN;
		if (col != COL_NONE && iter_q != ITER_LIMIT) begin
			if (act[4]) begin
				dec_dsp    = full ? DSP_STAT : DSP_SHIFT;
				dec_status = full ? ST_OVF : ST_OK;
			end else begin
				case (act)
					A_ACC:  dec_status = ST_ACC;
					A_RID:  dec_dsp = (top_q != '0) ? DSP_RID : DSP_STAT;
					A_RADD, A_RMUL: begin
						dec_dsp = (top_ge3 && nres_q < MAX_QUADS) ? DSP_RBIN : DSP_STAT;
					end
					A_RPAR: dec_dsp = top_ge3 ? DSP_RPAR : DSP_STAT;
					default: dec_dsp = DSP_STAT;
				endcase
			end
		end
	end

	assign cond = '{dispatch: dec_dsp, goto_ok: goto_ok, out_free: out_free};

	assign load_quad   = (ctrl.op == DP_RB2) && out_free;
	assign load_status = (ctrl.op == DP_STAT) && out_free;

	// Stack port steering.
	always_comb begin
		ps_we = 1'b0; ps_waddr = top_inc; ps_wdata = act[3:0];
		ps_re = 1'b0; ps_raddr = top_dec3;
		op_we = 1'b0; op_waddr = top_dec2; op_wdata = op_rdata;
		op_re = 1'b0; op_raddr = top_q;
		case (ctrl.op)
			DP_SHIFT: begin
				ps_we    = 1'b1;
				op_we    = 1'b1;
				op_waddr = top_inc;
				op_wdata = tok_opnd;
			end
			DP_RID: begin
				ps_re    = 1'b1;
				ps_raddr = top_dec1;
			end
			DP_RB0: op_re = 1'b1;
			DP_RB1: begin
				op_re    = 1'b1;
				op_raddr = top_dec2;
			end
			DP_RB2: begin
				op_we    = out_free;
				op_wdata = {OPK_TEMP, VALUE_BITS'(temp_next)};
				ps_re    = out_free;
			end
			DP_RP0: begin
				op_re    = 1'b1;
				op_raddr = top_dec1;
			end
			DP_RP1: begin
				op_we = 1'b1;
				ps_re = 1'b1;
			end
			DP_GOTO: begin
				ps_we    = goto_ok;
				ps_wdata = gnext[3:0];
			end
			default: ;
		endcase
	end

	slrq_ram #(.WIDTH(4), .DEPTH(STACK_DEPTH)) u_state_ram (
		.clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
		.re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
	);

	slrq_ram #(.WIDTH(OW), .DEPTH(STACK_DEPTH)) u_operand_ram (
		.clk(clk), .we(op_we), .waddr(op_waddr), .wdata(op_wdata),
		.re(op_re), .raddr(op_raddr), .rdata(op_rdata)
	);

	// The left operand comes straight from the operand RAM read data, which holds
	// while the quadruple waits for the output register.
	always_comb begin
		out_d = '0;
		if (load_quad) begin
			out_d.item_type   = ITEM_QUAD;
			out_d.quad_op     = (act == A_RMUL) ? QOP_MUL : QOP_ADD;
			out_d.left_kind   = op_rdata[OW-1:VALUE_BITS];
			out_d.left_value  = 16'(op_rdata[VALUE_BITS-1:0]);
			out_d.right_kind  = right_q[OW-1:VALUE_BITS];
			out_d.right_value = 16'(right_q[VALUE_BITS-1:0]);
			out_d.result_temp = temp_next;
			out_d.quad_number = quad_q;
		end else begin
			out_d.item_type = ITEM_STATUS;
			out_d.status    = status_q;
			out_d.last      = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == DP_LATCH && token_valid) begin
			tok_kind_q <= token.token_kind;
			tok_val_q  <= VALUE_BITS'(token.token_value);
		end
		if (ctrl.op == DP_RB1) begin
			right_q <= op_rdata;
		end
		if (load_quad || load_status) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= ST_SYN;
			iter_q      <= '0;
			nres_q      <= '0;
			top_q       <= '0;
			cur_state_q <= '0;
			temp_q      <= '0;
			quad_q      <= QUAD_BASE;
			out_valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				DP_LATCH: begin
					if (token_valid) begin
						status_q <= ST_SYN;
						iter_q   <= '0;
						nres_q   <= '0;
					end
				end
				DP_DECODE: begin
					status_q <= dec_status;
					iter_q   <= iter_q + 4'd1;
				end
				DP_SHIFT: begin
					top_q       <= top_inc;
					cur_state_q <= act[3:0];
				end
				DP_RID: top_q <= top_dec1;
				DP_RB2: begin
					if (out_free) begin
						temp_q <= temp_next;
						quad_q <= quad_q + 10'd1;
						nres_q <= nres_q + 2'd1;
						top_q  <= top_dec3;
					end
				end
				DP_RP1: top_q <= top_dec3;
				DP_GOTO: begin
					if (goto_ok) begin
						top_q       <= top_inc;
						cur_state_q <= gnext[3:0];
					end
				end
				DP_STAT: begin
					if (out_free && status_q != ST_OK) begin
						top_q       <= '0;
						cur_state_q <= '0;
					end
				end
				default: ;
			endcase
			if (load_quad || load_status) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== rtl/slr_expression_to_quadruples.sv =====
// Top level of the SLR expression parser that emits three-address quadruples.
// Depends on slrq_pkg, slrq_seq, slrq_dp and, through slrq_dp, slrq_ram.

// The block takes one token per request and answers with zero, one or two
// quadruple items followed by exactly one status item, whose last bit is set.
// Tokens are handled one at a time: a new token is taken only after the status
// item of the previous one has entered the output register. The work is run by
// a small microcode program, so the cost per token is the sum of its steps:
// taking the token, a decode for each table lookup, the shift, the status item,
// a pop and a goto for each identifier reduction, the steps U_RP0, U_RP1 and
// U_GOTO for each parenthesis reduction, and the steps U_RB0, U_RB1, U_RB2 and
// U_GOTO for each add or multiply reduction. The step sequence follows from the
// one read port of each stack memory, which makes the operands of a quadruple
// come out one per cycle. A stall on the result side holds the sequencer in
// the step that loads the output register. The stacks sit in two memories of
// STACK_DEPTH entries; an accept, a syntax error or an overflow only resets the
// stack pointer and the current state, so there is no clearing pass and the
// block is ready right after reset. The temporary and quadruple counters run on
// across parses and wrap at their field widths.
module slr_expression_to_quadruples #(
	parameter int STACK_DEPTH = 32,
	parameter int VALUE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              token_valid,
	output logic              token_ready,
	input  slrq_pkg::token_t  token,
	output logic              result_valid,
	input  logic              result_ready,
	output slrq_pkg::result_t result
);
	import slrq_pkg::*;

	ctrl_t ctrl;
	cond_t cond;

	// The sequencer walks the control store; the datapath reports the table
	// dispatch, the goto outcome and whether the output register can load.
	slrq_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.token_valid(token_valid),
		.cond(cond),
		.ctrl(ctrl)
	);

	slrq_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.token_valid(token_valid),
		.token(token),
		.result_ready(result_ready),
		.result_valid(result_valid),
		.result(result),
		.cond(cond)
	);

	// A token request is taken only in the idle step of the program.
	assign token_ready = ctrl.take_token;

	// Only one token is in work at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_ready) |=> !token_ready)
		else $error("token taken twice in a row");

	// A quadruple is always followed by a status item, so none can be pending
	// while the block waits for a new token.
	a_quad_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.item_type == ITEM_QUAD) |-> !token_ready)
		else $error("quadruple pending while idle");

	// The last flag marks status items and only them.
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last == result.item_type))
		else $error("last flag does not match item type");

endmodule
